// ===== rtl/scdp_pkg.sv =====
// Shared types and constants for the strided copy descriptor generator.
// No dependencies; every other file in rtl imports this package.
package scdp_pkg;

  // Fixed limits of the block.
  localparam int unsigned MaxPackets  = 64;
  localparam int unsigned AddressBits = 48;
  localparam int unsigned WordsPerDesc = 7;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegRowLen     = 3'd0;
  localparam logic [2:0] RegRowCount   = 3'd1;
  localparam logic [2:0] RegSliceCount = 3'd2;
  localparam logic [2:0] RegSrcRowPit  = 3'd3;
  localparam logic [2:0] RegDstRowPit  = 3'd4;
  localparam logic [2:0] RegSrcSlcPit  = 3'd5;
  localparam logic [2:0] RegDstSlcPit  = 3'd6;

  typedef struct packed {
    logic [20:0] row_len;
    logic [6:0]  rows;
    logic [6:0]  slices;
    logic [47:0] src_row_pitch;
    logic [47:0] dst_row_pitch;
    logic [47:0] src_slice_pitch;
    logic [47:0] dst_slice_pitch;
  } cfg_t;

  // One validated request handed from the front to the back.
  typedef struct packed {
    logic        reject;
    logic [63:0] src;
    logic [63:0] dst;
  } job_t;

endpackage

// ===== rtl/strided_copy_dma_packetizer_unit.sv =====
// Strided copy descriptor generator. The front validates a request step by
// step (two side checks with a row multiply each, two slice steps and the
// overlap compare) and takes no new request until the last one is pushed.
// The back sends one word per cycle while the output is not stalled,
// rows*slices words (one on reject); a two-entry queue decouples the two.
// Reset (async, active low) clears the control state and empties the queue.
module strided_copy_dma_packetizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] source_base_i,
  input  logic [63:0] source_offset_i,
  input  logic [63:0] dest_base_i,
  input  logic [63:0] dest_offset_i,
  input  logic [8:0]  capacity_words_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [63:0] src_address_o,
  output logic [63:0] dst_address_o,
  output logic [20:0] byte_count_o,
  output logic        last_o
);
  import scdp_pkg::*;

  cfg_t cfg_q;
  job_t push_job, pop_job;
  logic q_push, q_pop, q_full, q_empty;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRowLen:     cfg_q.row_len         <= cfg_wdata_i[20:0];
        RegRowCount:   cfg_q.rows            <= cfg_wdata_i[6:0];
        RegSliceCount: cfg_q.slices          <= cfg_wdata_i[6:0];
        RegSrcRowPit:  cfg_q.src_row_pitch   <= cfg_wdata_i;
        RegDstRowPit:  cfg_q.dst_row_pitch   <= cfg_wdata_i;
        RegSrcSlcPit:  cfg_q.src_slice_pitch <= cfg_wdata_i;
        RegDstSlcPit:  cfg_q.dst_slice_pitch <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  scdp_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_ready_o,
    .source_base_i, .source_offset_i, .dest_base_i, .dest_offset_i,
    .capacity_words_i,
    .push_o(q_push), .job_o(push_job), .full_i(q_full)
  );

  scdp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .push_data_i(push_job), .full_o(q_full),
    .pop_i(q_pop), .pop_data_o(pop_job), .empty_o(q_empty)
  );

  scdp_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .empty_i(q_empty), .job_i(pop_job), .pop_o(q_pop),
    .out_valid_o, .out_ready_i,
    .status_o, .src_address_o, .dst_address_o, .byte_count_o, .last_o
  );

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("queue overflow");

  // A rejected word is final and carries no addresses.
  a_reject_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (last_o && src_address_o == 64'd0 &&
    dst_address_o == 64'd0)) else $error("bad reject word");

  // Validation is sequenced through several states, so ready drops after an accept.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("double accept");

endmodule

// ===== rtl/scdp_queue.sv =====
// Two-entry queue of validated requests between the front and the back.
// Depends on scdp_pkg for job_t.
module scdp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scdp_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output scdp_pkg::job_t pop_data_o,
  output logic           empty_o
);
  import scdp_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (!push_i && pop_i) count_q <= count_q - 2'd1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/scdp_front.sv =====
// Request front end: takes one copy request and validates it step by step.
// Depends on scdp_pkg; pushes one job_t per request into the queue.
module scdp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scdp_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [63:0]    source_base_i,
  input  logic [63:0]    source_offset_i,
  input  logic [63:0]    dest_base_i,
  input  logic [63:0]    dest_offset_i,
  input  logic [8:0]     capacity_words_i,
  output logic           push_o,
  output scdp_pkg::job_t job_o,
  input  logic           full_i
);
  import scdp_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE, F_BASIC, F_SIDE, F_ROWMUL, F_ROWCHK,
    F_SLCMUL, F_SLCCHK, F_OVERLAP, F_PUSH
  } fstate_e;

  localparam logic [64:0] AddrLimit = 65'(1) << AddressBits;

  fstate_e     state_q;
  logic        sd_q;
  logic [63:0] base_q [2];
  logic [63:0] off_q [2];
  logic [8:0]  cap_q;
  logic [63:0] s_q, rem_q;
  logic [54:0] prod_q;
  logic [63:0] first_q [2];
  logic [54:0] ext_q [2];
  logic [63:0] end_q [2];
  logic [63:0] all_q [2];
  job_t        job_q;

  // Shared arithmetic for the side being checked.
  logic [63:0] b, o;
  logic [47:0] rp, sp;
  logic [64:0] s65, rem65, len65, sum65;
  logic        side_ok, basic_ok;
  logic [13:0] total;
  logic [16:0] total7;
  logic [54:0] rmul, smul, ext;

  always_comb begin
    b       = base_q[sd_q];
    o       = off_q[sd_q];
    rp      = sd_q ? cfg_i.dst_row_pitch : cfg_i.src_row_pitch;
    sp      = sd_q ? cfg_i.dst_slice_pitch : cfg_i.src_slice_pitch;
    len65   = 65'(cfg_i.row_len);
    s65     = {1'b0, b} + {1'b0, o};
    rem65   = AddrLimit - s65 - len65;
    side_ok = (b != 64'd0) && ({1'b0, b} < AddrLimit) &&
              ({1'b0, o} < AddrLimit - {1'b0, b}) &&
              (rp >= 48'(cfg_i.row_len)) && (rp != 48'd0) &&
              (s65[1:0] == 2'b00) && (rp[1:0] == 2'b00) &&
              (len65 <= AddrLimit - s65);
    total    = 14'(cfg_i.rows) * 14'(cfg_i.slices);
    total7   = 17'(total) * 17'(WordsPerDesc);
    basic_ok = (cfg_i.rows != 7'd0) && (cfg_i.slices != 7'd0) &&
               (cfg_i.row_len != 21'd0) && (cfg_i.row_len[1:0] == 2'b00) &&
               (total7 <= 17'(cap_q)) && (32'(total) <= 32'(MaxPackets));
    rmul  = 55'(cfg_i.rows - 7'd1) * 55'(rp);
    smul  = 55'(cfg_i.slices - 7'd1) * 55'(sp);
    ext   = prod_q + 55'(cfg_i.row_len);
    sum65 = {1'b0, end_q[sd_q]} + 65'(prod_q);
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign job_o      = job_q;

  // Validation sequencer; any failed check goes straight to the push with
  // the reject flag set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      sd_q    <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            base_q[0] <= source_base_i;
            off_q[0]  <= source_offset_i;
            base_q[1] <= dest_base_i;
            off_q[1]  <= dest_offset_i;
            cap_q     <= capacity_words_i;
            sd_q      <= 1'b0;
            state_q   <= F_BASIC;
          end
        end
        F_BASIC: begin
          job_q <= '{reject: 1'b1, src: 64'd0, dst: 64'd0};
          state_q <= basic_ok ? F_SIDE : F_PUSH;
        end
        F_SIDE: begin
          s_q     <= s65[63:0];
          rem_q   <= rem65[63:0];
          state_q <= side_ok ? F_ROWMUL : F_PUSH;
        end
        F_ROWMUL: begin
          prod_q  <= rmul;
          state_q <= F_ROWCHK;
        end
        F_ROWCHK: begin
          if (64'(prod_q) > rem_q) begin
            state_q <= F_PUSH;
          end else begin
            first_q[sd_q] <= s_q;
            ext_q[sd_q]   <= ext;
            end_q[sd_q]   <= s_q + 64'(ext);
            sd_q          <= ~sd_q;
            state_q       <= sd_q ? F_SLCMUL : F_SIDE;
          end
        end
        F_SLCMUL: begin
          prod_q  <= smul;
          state_q <= ((55'(sp) < ext_q[sd_q]) || (sp == 48'd0)) ? F_PUSH : F_SLCCHK;
        end
        F_SLCCHK: begin
          if (sum65[64]) begin
            state_q <= F_PUSH;
          end else begin
            all_q[sd_q] <= sum65[63:0];
            sd_q        <= ~sd_q;
            state_q     <= sd_q ? F_OVERLAP : F_SLCMUL;
          end
        end
        F_OVERLAP: begin
          if (!((first_q[0] < all_q[1]) && (first_q[1] < all_q[0]))) begin
            job_q <= '{reject: 1'b0, src: first_q[0], dst: first_q[1]};
          end
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/scdp_back.sv =====
// Descriptor back end: expands one queued job into row words, slice-major.
// Depends on scdp_pkg; holds the output register of the block.
module scdp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scdp_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  scdp_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           status_o,
  output logic [63:0]    src_address_o,
  output logic [63:0]    dst_address_o,
  output logic [20:0]    byte_count_o,
  output logic           last_o
);
  import scdp_pkg::*;

  typedef enum logic {B_IDLE, B_RUN} bstate_e;

  bstate_e     state_q;
  logic        rej_q;
  logic [6:0]  rw_q, sl_q;
  logic [63:0] rs_q, rd_q, ss_q, sd_q;
  logic        out_free, row_end, fin;

  assign out_free = !out_valid_o || out_ready_i;
  assign row_end  = (rw_q == cfg_i.rows - 7'd1);
  assign fin      = rej_q || (row_end && (sl_q == cfg_i.slices - 7'd1));
  assign pop_o    = (state_q == B_IDLE) && !empty_i;

  // Walk rows within a slice, then step to the next slice.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (out_ready_i) out_valid_o <= 1'b0;
          if (!empty_i) begin
            rej_q   <= job_i.reject;
            rs_q    <= job_i.src;
            ss_q    <= job_i.src;
            rd_q    <= job_i.dst;
            sd_q    <= job_i.dst;
            rw_q    <= 7'd0;
            sl_q    <= 7'd0;
            state_q <= B_RUN;
          end
        end
        B_RUN: begin
          if (out_free) begin
            out_valid_o   <= 1'b1;
            status_o      <= rej_q;
            src_address_o <= rej_q ? 64'd0 : rs_q;
            dst_address_o <= rej_q ? 64'd0 : rd_q;
            byte_count_o  <= rej_q ? 21'd0 : cfg_i.row_len;
            last_o        <= fin;
            if (fin) state_q <= B_IDLE;
            if (row_end) begin
              rw_q <= 7'd0;
              sl_q <= sl_q + 7'd1;
              ss_q <= ss_q + 64'(cfg_i.src_slice_pitch);
              sd_q <= sd_q + 64'(cfg_i.dst_slice_pitch);
              rs_q <= ss_q + 64'(cfg_i.src_slice_pitch);
              rd_q <= sd_q + 64'(cfg_i.dst_slice_pitch);
            end else begin
              rw_q <= rw_q + 7'd1;
              rs_q <= rs_q + 64'(cfg_i.src_row_pitch);
              rd_q <= rd_q + 64'(cfg_i.dst_row_pitch);
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
